/* src/rrtt_pkg.sv */
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants for the round-robin task table: operation
// codes, slot status codes, state encoding and the default table size.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtt_pkg;

    // default number of task slots
    localparam int SLOTS_DEF = 16;

    // operation codes carried in the func field
    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_SPAWN = 2'd1,
        FN_KILL  = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    // slot status codes
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_TINC  = 10'b00_0000_0010,
        S_TSCAN = 10'b00_0000_0100,
        S_TDEM  = 10'b00_0000_1000,
        S_KFIND = 10'b00_0001_0000,
        S_KPASS = 10'b00_0010_0000,
        S_KKEY  = 10'b00_0100_0000,
        S_KEXP  = 10'b00_1000_0000,
        S_KMARK = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

/* src/round_robin_task_table.sv */
// Sequencing: spawn and no-op go straight to the result; tick reads the running slot, then
// scans the ring for the next runnable slot (one slot status read per cycle) and, on a switch,
// demotes the old one; kill searches slots 1 and up for the id, then runs one host sweep per
// killed slot, repeats the passes while the dependent set grows, and ends with a marking sweep.
// Throughput: one transaction at a time; the input stalls until the sequencer is back in idle.
// Reset: synchronous; slot 0 is RUNNING with id 0, one slot used, next id 1.
// ----------------------------------------------------------------------------
// round_robin_task_table
// Task table with spawn, transitive kill and round-robin tick. Slot fields
// live in memories with one write and one read port; a small sequencer walks them one slot per
// cycle. Slot 0 is kept in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_table #(
    parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_target_id,
    input  wire logic [31:0] i_host_id,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_assigned_id,
    output logic             o_kill_found,
    output logic [3:0]       o_running_slot,
    output logic [31:0]      o_running_id
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;

    // slot memories (entry 0 unused, slot 0 held in registers)
    logic [31:0] r_id_mem   [SLOTS];
    logic [31:0] r_host_mem [SLOTS];
    logic [1:0]  r_stat_mem [SLOTS];
    logic [31:0] r_tick_mem [SLOTS];

    // registered read data
    logic [31:0] r_id_q, r_host_q, r_tick_q;
    logic [1:0]  r_stat_q;
    logic        r_rd_zero, n_rd_zero;

    // memory port controls
    logic [SW-1:0] w_rd_addr, w_wr_addr;
    logic          w_we_spawn, w_we_stat, w_we_tick;
    logic [1:0]    w_stat_wd;
    logic [31:0]   w_tick_wd;

    // read data with slot 0 folded in
    logic [31:0] w_id_rd, w_host_rd, w_tick_rd;
    logic [1:0]  w_stat_rd;

    // sequencer and table state
    rrtt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_used, n_used;
    logic [SW-1:0]    r_cur, n_cur;
    logic [31:0]      r_cur_id, n_cur_id;
    logic [31:0]      r_next_id, n_next_id;
    logic [1:0]       r_stat0, n_stat0;
    logic [31:0]      r_tick0, n_tick0;
    logic [CW-1:0]    r_scan, n_scan;
    logic [SW-1:0]    r_scan_q, n_scan_q;
    logic             r_dv, n_dv;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [1:0]       r_cur_stat, n_cur_stat;
    logic [SW-1:0]    r_old, n_old;
    logic [31:0]      r_key, n_key;
    logic [SLOTS-1:0] r_hit, n_hit;
    logic [SLOTS-1:0] r_done, n_done;
    logic             r_grew, n_grew;
    logic [CW-1:0]    r_p, n_p;
    logic [31:0]      r_res_assigned, n_res_assigned;
    logic             r_res_found, n_res_found;
    logic             r_out_valid, n_out_valid;
    logic             w_load_out;
    logic             w_accept;

    // ring successor of the scan pointer
    logic [CW-1:0] w_scan_wrap;
    logic [CW-1:0] w_cur_wrap;
    logic          w_runnable;

    assign w_accept   = i_in_valid && (r_state == rrtt_pkg::S_IDLE);
    assign o_in_stall = (r_state != rrtt_pkg::S_IDLE);

    assign w_id_rd   = r_rd_zero ? 32'd0   : r_id_q;
    assign w_host_rd = r_rd_zero ? 32'd0   : r_host_q;
    assign w_tick_rd = r_rd_zero ? r_tick0 : r_tick_q;
    assign w_stat_rd = r_rd_zero ? r_stat0 : r_stat_q;

    assign w_scan_wrap = (r_scan == r_used - 1'b1) ? '0 : r_scan + 1'b1;
    assign w_cur_wrap  = (CW'(r_cur) == r_used - 1'b1) ? '0 : CW'(r_cur) + 1'b1;
    assign w_runnable  = (w_stat_rd == rrtt_pkg::ST_READY) ||
                         (w_stat_rd == rrtt_pkg::ST_RUNNING);

    // slot memories, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we_spawn) begin
            r_id_mem[w_wr_addr]   <= r_next_id;
            r_host_mem[w_wr_addr] <= i_host_id;
        end
        if (w_we_stat) begin
            r_stat_mem[w_wr_addr] <= w_stat_wd;
        end
        if (w_we_tick) begin
            r_tick_mem[w_wr_addr] <= w_tick_wd;
        end
        r_id_q   <= r_id_mem[w_rd_addr];
        r_host_q <= r_host_mem[w_rd_addr];
        r_stat_q <= r_stat_mem[w_rd_addr];
        r_tick_q <= r_tick_mem[w_rd_addr];
    end

    // sequencer next state and memory port control
    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_cur          = r_cur;
        n_cur_id       = r_cur_id;
        n_next_id      = r_next_id;
        n_stat0        = r_stat0;
        n_tick0        = r_tick0;
        n_scan         = r_scan;
        n_scan_q       = r_scan_q;
        n_dv           = r_dv;
        n_cnt          = r_cnt;
        n_cur_stat     = r_cur_stat;
        n_old          = r_old;
        n_key          = r_key;
        n_hit          = r_hit;
        n_done         = r_done;
        n_grew         = r_grew;
        n_p            = r_p;
        n_res_assigned = r_res_assigned;
        n_res_found    = r_res_found;
        n_out_valid    = r_out_valid && i_out_stall;
        w_load_out     = 1'b0;
        w_rd_addr      = r_scan[SW-1:0];
        w_wr_addr      = r_scan_q;
        w_we_spawn     = 1'b0;
        w_we_stat      = 1'b0;
        w_we_tick      = 1'b0;
        w_stat_wd      = rrtt_pkg::ST_READY;
        w_tick_wd      = w_tick_rd + 32'd1;

        case (r_state)
            rrtt_pkg::S_IDLE: begin
                n_res_assigned = 32'd0;
                n_res_found    = 1'b0;
                if (w_accept) begin
                    case (i_func)
                        rrtt_pkg::FN_TICK: begin
                            // read tick count and status of the running slot
                            w_rd_addr = r_cur;
                            n_scan    = w_cur_wrap;
                            n_state   = rrtt_pkg::S_TINC;
                        end
                        rrtt_pkg::FN_SPAWN: begin
                            // append a ready slot at the fill point
                            if (r_used < CW'(SLOTS)) begin
                                w_wr_addr      = r_used[SW-1:0];
                                w_we_spawn     = 1'b1;
                                w_we_stat      = 1'b1;
                                w_we_tick      = 1'b1;
                                w_stat_wd      = rrtt_pkg::ST_READY;
                                w_tick_wd      = 32'd0;
                                n_res_assigned = r_next_id;
                                n_used         = r_used + 1'b1;
                                n_next_id      = r_next_id + 32'd1;
                            end
                            n_state = rrtt_pkg::S_DONE;
                        end
                        rrtt_pkg::FN_KILL: begin
                            // start the id search at slot 1
                            w_rd_addr = SW'(1);
                            n_scan    = CW'(2);
                            n_scan_q  = SW'(1);
                            n_dv      = (r_used > CW'(1));
                            n_key     = i_target_id;
                            n_hit     = '0;
                            n_done    = '0;
                            n_grew    = 1'b0;
                            n_state   = (i_target_id == 32'd0) ? rrtt_pkg::S_DONE
                                                               : rrtt_pkg::S_KFIND;
                        end
                        default: begin
                            n_state = rrtt_pkg::S_DONE;
                        end
                    endcase
                end
            end

            rrtt_pkg::S_TINC: begin
                // charge the tick, start the ring scan
                w_wr_addr  = r_cur;
                w_we_tick  = 1'b1;
                w_tick_wd  = w_tick_rd + 32'd1;
                if (r_cur == '0) begin
                    n_tick0 = w_tick_rd + 32'd1;
                end
                n_cur_stat = w_stat_rd;
                w_rd_addr  = r_scan[SW-1:0];
                n_scan_q   = r_scan[SW-1:0];
                n_scan     = w_scan_wrap;
                n_cnt      = CW'(1);
                n_state    = rrtt_pkg::S_TSCAN;
            end

            rrtt_pkg::S_TSCAN: begin
                // one slot status checked per cycle
                w_rd_addr = r_scan[SW-1:0];
                n_scan_q  = r_scan[SW-1:0];
                n_scan    = w_scan_wrap;
                if (w_runnable) begin
                    if (r_scan_q != r_cur) begin
                        w_wr_addr = r_scan_q;
                        w_we_stat = 1'b1;
                        w_stat_wd = rrtt_pkg::ST_RUNNING;
                        if (r_scan_q == '0) begin
                            n_stat0 = rrtt_pkg::ST_RUNNING;
                        end
                        n_cur    = r_scan_q;
                        n_cur_id = w_id_rd;
                        n_old    = r_cur;
                        n_state  = rrtt_pkg::S_TDEM;
                    end else begin
                        n_state = rrtt_pkg::S_DONE;
                    end
                end else if (r_cnt == r_used) begin
                    n_state = rrtt_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            rrtt_pkg::S_TDEM: begin
                // old running slot goes back to ready
                if (r_cur_stat == rrtt_pkg::ST_RUNNING) begin
                    w_wr_addr = r_old;
                    w_we_stat = 1'b1;
                    w_stat_wd = rrtt_pkg::ST_READY;
                    if (r_old == '0) begin
                        n_stat0 = rrtt_pkg::ST_READY;
                    end
                end
                n_state = rrtt_pkg::S_DONE;
            end

            rrtt_pkg::S_KFIND: begin
                // search slots 1 and up for the target id
                w_rd_addr = r_scan[SW-1:0];
                n_scan_q  = r_scan[SW-1:0];
                n_dv      = (r_scan < r_used);
                n_scan    = (r_scan < r_used) ? r_scan + 1'b1 : r_scan;
                if (r_dv && (w_id_rd == r_key)) begin
                    n_hit[r_scan_q] = 1'b1;
                    n_p             = CW'(1);
                    n_grew          = 1'b0;
                    n_state         = rrtt_pkg::S_KPASS;
                end else if (!r_dv) begin
                    n_state = rrtt_pkg::S_DONE;
                end
            end

            rrtt_pkg::S_KPASS: begin
                // find the next killed slot whose dependents are not yet swept
                if (r_p >= r_used) begin
                    n_p    = CW'(1);
                    n_grew = 1'b0;
                    if (!r_grew) begin
                        n_state = rrtt_pkg::S_KMARK;
                    end
                end else if (r_hit[r_p[SW-1:0]] && !r_done[r_p[SW-1:0]]) begin
                    w_rd_addr             = r_p[SW-1:0];
                    n_done[r_p[SW-1:0]]   = 1'b1;
                    n_state               = rrtt_pkg::S_KKEY;
                end else begin
                    n_p = r_p + 1'b1;
                end
            end

            rrtt_pkg::S_KKEY: begin
                // latch the killed id, start the host sweep
                n_key     = w_id_rd;
                w_rd_addr = SW'(1);
                n_scan    = CW'(2);
                n_scan_q  = SW'(1);
                n_dv      = (r_used > CW'(1));
                n_state   = rrtt_pkg::S_KEXP;
            end

            rrtt_pkg::S_KEXP: begin
                // mark every slot hosted by the latched id
                w_rd_addr = r_scan[SW-1:0];
                n_scan_q  = r_scan[SW-1:0];
                n_dv      = (r_scan < r_used);
                n_scan    = (r_scan < r_used) ? r_scan + 1'b1 : r_scan;
                if (r_dv && (w_host_rd == r_key) && !r_hit[r_scan_q]) begin
                    n_hit[r_scan_q] = 1'b1;
                    n_grew          = 1'b1;
                end
                if (!r_dv) begin
                    n_p     = r_p + 1'b1;
                    n_state = rrtt_pkg::S_KPASS;
                end
            end

            rrtt_pkg::S_KMARK: begin
                // write dead status into every killed slot
                if (r_p >= r_used) begin
                    n_res_found = 1'b1;
                    n_state     = rrtt_pkg::S_DONE;
                end else begin
                    if (r_hit[r_p[SW-1:0]]) begin
                        w_wr_addr = r_p[SW-1:0];
                        w_we_stat = 1'b1;
                        w_stat_wd = rrtt_pkg::ST_DEAD;
                    end
                    n_p = r_p + 1'b1;
                end
            end

            rrtt_pkg::S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = rrtt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rrtt_pkg::S_IDLE;
            end
        endcase

        n_rd_zero = (w_rd_addr == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrtt_pkg::S_IDLE;
            r_used      <= CW'(1);
            r_cur       <= '0;
            r_cur_id    <= 32'd0;
            r_next_id   <= 32'd1;
            r_stat0     <= rrtt_pkg::ST_RUNNING;
            r_tick0     <= 32'd0;
            r_out_valid <= 1'b0;
            r_grew      <= 1'b0;
            r_dv        <= 1'b0;
            r_rd_zero   <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_cur_id    <= n_cur_id;
            r_next_id   <= n_next_id;
            r_stat0     <= n_stat0;
            r_tick0     <= n_tick0;
            r_out_valid <= n_out_valid;
            r_grew      <= n_grew;
            r_dv        <= n_dv;
            r_rd_zero   <= n_rd_zero;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_scan         <= n_scan;
        r_scan_q       <= n_scan_q;
        r_cnt          <= n_cnt;
        r_cur_stat     <= n_cur_stat;
        r_old          <= n_old;
        r_key          <= n_key;
        r_hit          <= n_hit;
        r_done         <= n_done;
        r_p            <= n_p;
        r_res_assigned <= n_res_assigned;
        r_res_found    <= n_res_found;
        if (w_load_out) begin
            o_assigned_id  <= r_res_assigned;
            o_kill_found   <= r_res_found;
            o_running_slot <= 4'(r_cur);
            o_running_id   <= r_cur_id;
        end
    end

    assign o_out_valid = r_out_valid;

    // table fill stays within bounds
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used >= CW'(1)) && (r_used <= CW'(SLOTS)))
        else $error("used slot count out of range");

    // running slot always lies inside the filled part of the table
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cur) < r_used)
        else $error("running slot beyond fill point");

    // slot 0 always carries id 0
    a_slot0_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) |-> (r_cur_id == 32'd0))
        else $error("running id mismatch on slot 0");

    // a spawn into a table with room grows it by one slot
    a_spawn_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func == rrtt_pkg::FN_SPAWN) && (r_used < CW'(SLOTS)))
        |=> (r_used == $past(r_used) + 1'b1))
        else $error("spawn did not take a slot");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin task table. A short table of
// directed transactions covers every operation, the extreme field values
// and the corner cases of kill and spawn. Random traffic follows: mostly
// ticks and kills against a full table, with random gaps on the input
// side and random stalls on the output side. Every result is compared field by field with the
// outcome of a behavioural scheduler kept here, or with the answers pinned in a directed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int TBL_SLOTS    = rrtt_pkg::SLOTS_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 300;

    // one result of the table as seen on the output channel
    typedef struct {
        logic [31:0] assigned_id;
        logic        kill_found;
        logic [3:0]  running_slot;
        logic [31:0] running_id;
    } t_sched_outcome;

    // one directed transaction; pinned rows carry the obvious answers
    typedef struct {
        rrtt_pkg::t_func op;
        logic [31:0]     target_id;
        logic [31:0]     host_id;
        bit              pinned;
        logic [31:0]     assigned_id;
        logic            kill_found;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [31:0] i_target_id;
    logic [31:0] i_host_id;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_assigned_id;
    logic        o_kill_found;
    logic [3:0]  o_running_slot;
    logic [31:0] o_running_id;

    // pinned answers travelling with the transaction on offer
    bit          row_pinned;
    logic [31:0] pin_assigned;
    logic        pin_found;

    // scheduler state mirrored in the bench
    logic [31:0] tbl_id     [TBL_SLOTS];
    logic [31:0] tbl_host   [TBL_SLOTS];
    logic [1:0]  tbl_status [TBL_SLOTS];
    logic [31:0] tbl_ticks  [TBL_SLOTS];
    int unsigned tbl_used;
    int unsigned tbl_cur;
    logic [31:0] tbl_next_id;

    t_sched_outcome sched_outcomes_q [$];
    int error_count  = 0;
    int results_seen = 0;
    int tx_calm      = 0;

    t_plan_row directed_plan [25] = '{
        // lone slot 0: tick, no-op and both kill refusals
        '{rrtt_pkg::FN_TICK,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'd0,  1'b0},
        '{rrtt_pkg::FN_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0,  1'b0},
        '{rrtt_pkg::FN_KILL,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0,  1'b0},
        '{rrtt_pkg::FN_KILL,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0,  1'b0},
        // a chain 1 <- 2 <- 3 and a ring 4 -> 6 -> 5 -> 4
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'd1,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'd2,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0002, 1'b1, 32'd3,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0006, 1'b1, 32'd4,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0004, 1'b1, 32'd5,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'd6,  1'b0},
        // kill the running task with its chain, then the ring twice
        '{rrtt_pkg::FN_TICK,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0,  1'b0},
        '{rrtt_pkg::FN_KILL,  32'h0000_0001, 32'h0000_0000, 1'b1, 32'd0,  1'b1},
        '{rrtt_pkg::FN_TICK,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0,  1'b0},
        '{rrtt_pkg::FN_KILL,  32'h0000_0004, 32'h0000_0000, 1'b1, 32'd0,  1'b1},
        '{rrtt_pkg::FN_KILL,  32'h0000_0004, 32'h0000_0000, 1'b1, 32'd0,  1'b1},
        // fill the table: self host, dead host, nested hosts
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd7,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0008, 1'b1, 32'd8,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'd9,  1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'd10, 1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_000A, 1'b1, 32'd11, 1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_000B, 1'b1, 32'd12, 1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_000A, 1'b1, 32'd13, 1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'd14, 1'b0},
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'd15, 1'b0},
        // table full
        '{rrtt_pkg::FN_SPAWN, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'd0,  1'b0}
    };

    round_robin_task_table u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_target_id    (i_target_id),
        .i_host_id      (i_host_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_assigned_id  (o_assigned_id),
        .o_kill_found   (o_kill_found),
        .o_running_slot (o_running_slot),
        .o_running_id   (o_running_id)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // print one mismatch line and count it
    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // idle run length: mostly short, now and then long
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // apply one operation to the mirrored table and return its outcome
    function automatic t_sched_outcome schedule_step(input rrtt_pkg::t_func op,
                                                     input logic [31:0] target,
                                                     input logic [31:0] host);
        t_sched_outcome res;
        int unsigned    i;
        int unsigned    j;
        int unsigned    nx;
        bit             grew;
        bit             hit [TBL_SLOTS];
        res.assigned_id = '0;
        res.kill_found  = 1'b0;
        case (op)
            rrtt_pkg::FN_TICK: begin
                if (tbl_cur < tbl_used) begin
                    tbl_ticks[tbl_cur] = tbl_ticks[tbl_cur] + 32'd1;
                    // first runnable slot after the current one, wrapping round
                    for (i = 1; i <= tbl_used; i++) begin
                        nx = (tbl_cur + i) % tbl_used;
                        if (tbl_status[nx] == rrtt_pkg::ST_READY ||
                            tbl_status[nx] == rrtt_pkg::ST_RUNNING) begin
                            if (nx != tbl_cur) begin
                                if (tbl_status[tbl_cur] == rrtt_pkg::ST_RUNNING) begin
                                    tbl_status[tbl_cur] = rrtt_pkg::ST_READY;
                                end
                                tbl_status[nx] = rrtt_pkg::ST_RUNNING;
                                tbl_cur = nx;
                            end
                            break;
                        end
                    end
                end
            end
            rrtt_pkg::FN_SPAWN: begin
                if (tbl_used < TBL_SLOTS) begin
                    tbl_id[tbl_used]     = tbl_next_id;
                    tbl_host[tbl_used]   = host;
                    tbl_status[tbl_used] = rrtt_pkg::ST_READY;
                    tbl_ticks[tbl_used]  = '0;
                    res.assigned_id      = tbl_next_id;
                    tbl_next_id          = tbl_next_id + 32'd1;
                    tbl_used++;
                end
            end
            rrtt_pkg::FN_KILL: begin
                for (i = 0; i < TBL_SLOTS; i++) begin
                    hit[i] = 1'b0;
                end
                if (target != '0) begin
                    for (i = 1; i < tbl_used; i++) begin
                        if (tbl_id[i] == target) begin
                            hit[i]         = 1'b1;
                            res.kill_found = 1'b1;
                            break;
                        end
                    end
                end
                if (res.kill_found) begin
                    // grow the dependent set until it stops changing
                    do begin
                        grew = 1'b0;
                        for (j = 1; j < tbl_used; j++) begin
                            if (!hit[j]) begin
                                for (i = 1; i < tbl_used; i++) begin
                                    if (hit[i] && tbl_host[j] == tbl_id[i]) begin
                                        hit[j] = 1'b1;
                                        grew   = 1'b1;
                                        break;
                                    end
                                end
                            end
                        end
                    end while (grew);
                    for (i = 1; i < tbl_used; i++) begin
                        if (hit[i]) begin
                            tbl_status[i] = rrtt_pkg::ST_DEAD;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.running_slot = 4'(tbl_cur);
        res.running_id   = tbl_id[tbl_cur];
        return res;
    endfunction

    // offer one transaction at a falling edge and hold it until taken
    task automatic offer_item(input rrtt_pkg::t_func op, input logic [31:0] target,
                              input logic [31:0] host, input bit pinned,
                              input logic [31:0] p_assigned, input logic p_found);
        int gap;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3) begin
                tx_calm = $urandom_range(10, 40);
            end
            gap = ($urandom_range(0, 99) < 50) ? 0 : idle_length();
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_func       = op;
        i_target_id  = target;
        i_host_id    = host;
        row_pinned   = pinned;
        pin_assigned = p_assigned;
        pin_found    = p_found;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // predict at input acceptance, check at output acceptance
    always @(posedge i_clk) begin : scoreboard
        t_sched_outcome want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (sched_outcomes_q.size() == 0) begin
                    report_error($sformatf("result %0d with no transaction pending",
                                           results_seen));
                end else begin
                    want = sched_outcomes_q.pop_front();
                    if (o_assigned_id !== want.assigned_id) begin
                        report_error($sformatf("result %0d assigned_id %h, wanted %h",
                                               results_seen, o_assigned_id, want.assigned_id));
                    end
                    if (o_kill_found !== want.kill_found) begin
                        report_error($sformatf("result %0d kill_found %b, wanted %b",
                                               results_seen, o_kill_found, want.kill_found));
                    end
                    if (o_running_slot !== want.running_slot) begin
                        report_error($sformatf("result %0d running_slot %0d, wanted %0d",
                                               results_seen, o_running_slot,
                                               want.running_slot));
                    end
                    if (o_running_id !== want.running_id) begin
                        report_error($sformatf("result %0d running_id %h, wanted %h",
                                               results_seen, o_running_id, want.running_id));
                    end
                end
                results_seen++;
            end
            if (i_in_valid && !o_in_stall) begin
                want = schedule_step(rrtt_pkg::t_func'(i_func), i_target_id, i_host_id);
                if (row_pinned) begin
                    want.assigned_id = pin_assigned;
                    want.kill_found  = pin_found;
                end
                sched_outcomes_q.push_back(want);
            end
        end
    end

    // output side: random stalls, calm stretches and one long hold-off
    initial begin : receiver
        int  rx_hold;
        int  rx_calm;
        bit  pressure_done;
        rx_hold       = 0;
        rx_calm       = 0;
        pressure_done = 1'b0;
        i_out_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
            end else if (!pressure_done && results_seen >= HOLD_AFTER) begin
                pressure_done = 1'b1;
                rx_hold       = HOLD_CYCLES;
            end else if (rx_calm > 0) begin
                rx_calm--;
            end else if ($urandom_range(0, 99) < 3) begin
                rx_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 99) < 30) begin
                rx_hold = idle_length();
            end
            i_out_stall = (rx_hold > 0);
        end
    end

    // input side: reset, directed table, random traffic, drain
    initial begin : stimulus
        int              n;
        int              pick;
        rrtt_pkg::t_func op;
        logic [31:0]     target;
        logic [31:0]     host;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = rrtt_pkg::FN_NOP;
        i_target_id  = '0;
        i_host_id    = '0;
        row_pinned   = 1'b0;
        pin_assigned = '0;
        pin_found    = 1'b0;
        for (n = 0; n < TBL_SLOTS; n++) begin
            tbl_id[n]     = '0;
            tbl_host[n]   = '0;
            tbl_status[n] = rrtt_pkg::ST_READY;
            tbl_ticks[n]  = '0;
        end
        tbl_status[0] = rrtt_pkg::ST_RUNNING;
        tbl_used      = 1;
        tbl_cur       = 0;
        tbl_next_id   = 32'd1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_plan[k]) begin
            offer_item(directed_plan[k].op, directed_plan[k].target_id,
                       directed_plan[k].host_id, directed_plan[k].pinned,
                       directed_plan[k].assigned_id, directed_plan[k].kill_found);
        end

        // random traffic on the full table
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick   = $urandom_range(0, 99);
            target = $urandom;
            host   = $urandom;
            if (pick < 50) begin
                op = rrtt_pkg::FN_TICK;
            end else if (pick < 65) begin
                op = rrtt_pkg::FN_SPAWN;
                if ($urandom_range(0, 1) == 1) begin
                    host = $urandom_range(0, 16);
                end
            end else if (pick < 95) begin
                op = rrtt_pkg::FN_KILL;
                case ($urandom_range(0, 7))
                    0:       target = $urandom_range(1, TBL_SLOTS - 1);
                    1:       target = '0;
                    2, 3:    target = $urandom_range(TBL_SLOTS, TBL_SLOTS + 4);
                    default: target = $urandom;
                endcase
            end else begin
                op = rrtt_pkg::FN_NOP;
            end
            offer_item(op, target, host, 1'b0, '0, 1'b0);
        end
        i_in_valid = 1'b0;

        // drain, then watch for stray results
        while (sched_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
